// ===== rtl/core/cak_pkg.sv =====
package cak_pkg;

    localparam int PORT_W      = 16;
    localparam int SEQ_W       = 16;
    localparam int SLOT_OUT_W  = 4;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        ST_ACCEPT  = 3'd0,
        ST_ORDER   = 3'd1,
        ST_DROP    = 3'd2,
        ST_CORRUPT = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    localparam logic [CFG_INDEX_W-1:0] REG_DROP_PERIOD    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CORRUPT_PERIOD = 8'd1;

    localparam logic [SEQ_W-1:0] SEQ_ONE = 16'd1;

    typedef struct packed {
        logic [PORT_W-1:0] src_port;
        logic [SEQ_W-1:0]  seq_num;
        logic [SEQ_W-1:0]  total_packets;
        logic              crc_ok;
    } in_item_t;

    typedef struct packed {
        logic [SEQ_W-1:0]      ack_num;
        status_t               status;
        logic [SLOT_OUT_W-1:0] client_slot;
        logic                  transfer_done;
    } out_item_t;

    // classified packet handed from lookup to execution
    typedef struct packed {
        logic [SEQ_W-1:0] seq_num;
        logic [SEQ_W-1:0] total_packets;
        logic             fresh;
        logic             table_full;
        logic             good;
    } job_t;

endpackage

// ===== rtl/core/cak_front.sv =====
module cak_front #(
    parameter int MAX_CLIENTS = 16,
    parameter int SLOT_W      = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cak_pkg::in_item_t    in_data,
    input  logic                 q_full,
    output logic                 q_push,
    output logic [SLOT_W-1:0]    q_slot,
    output cak_pkg::job_t        q_job
);

    logic [cak_pkg::PORT_W-1:0] port_table_reg [MAX_CLIENTS];
    logic [MAX_CLIENTS-1:0]     valid_reg;
    logic [MAX_CLIENTS-1:0]     valid_next;
    logic [MAX_CLIENTS-1:0]     hit_vec;
    logic [MAX_CLIENTS-1:0]     free_vec;
    logic [SLOT_W-1:0]          hit_slot;
    logic [SLOT_W-1:0]          free_slot;
    logic                       any_hit;
    logic                       any_free;
    logic                       accept;
    logic                       insert;

    always_comb
    begin
        for (int i = 0; i < MAX_CLIENTS; i++)
        begin
            hit_vec[i]  = valid_reg[i] && (port_table_reg[i] == in_data.src_port);
            free_vec[i] = !valid_reg[i];
        end
    end

    // lowest matching and lowest free slot
    always_comb
    begin
        hit_slot  = '0;
        free_slot = '0;
        for (int i = MAX_CLIENTS - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_slot = SLOT_W'(i);
            end
            if (free_vec[i])
            begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    assign any_hit  = |hit_vec;
    assign any_free = |free_vec;
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    // unknown port is inserted even for a bad packet
    assign insert   = accept && !any_hit && any_free;

    always_comb
    begin
        valid_next = valid_reg;
        if (insert)
        begin
            valid_next[free_slot] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (insert)
        begin
            port_table_reg[free_slot] <= in_data.src_port;
        end
    end

    // a bad packet from a new client still goes back to seed its expected sequence
    assign q_push                = accept && (in_data.crc_ok || insert);
    assign q_slot                = any_hit ? hit_slot : free_slot;
    assign q_job.seq_num         = in_data.seq_num;
    assign q_job.total_packets   = in_data.total_packets;
    assign q_job.fresh           = !any_hit && any_free;
    assign q_job.table_full      = !any_hit && !any_free;
    assign q_job.good            = in_data.crc_ok;

    a_port_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("port matches more than one slot");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        insert |=> ($countones(valid_reg) == $past($countones(valid_reg)) + 1))
        else $error("insert did not add a client");

    a_full_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        !any_free |=> !any_free)
        else $error("client table shrank");

endmodule

// ===== rtl/core/cak_fifo.sv =====
module cak_fifo #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/cak_back.sv =====
module cak_back #(
    parameter int MAX_CLIENTS = 16,
    parameter int SLOT_W      = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cak_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [cak_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 q_empty,
    output logic                                 q_pop,
    input  logic [SLOT_W-1:0]                    q_slot,
    input  cak_pkg::job_t                        q_job,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output cak_pkg::out_item_t                   out_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [cak_pkg::SEQ_W-1:0]   drop_period_reg;
    logic [cak_pkg::SEQ_W-1:0]   drop_period_next;
    logic [cak_pkg::SEQ_W-1:0]   corrupt_period_reg;
    logic [cak_pkg::SEQ_W-1:0]   corrupt_period_next;
    logic [cak_pkg::SEQ_W-1:0]   drop_target_reg;
    logic [cak_pkg::SEQ_W-1:0]   drop_target_next;
    logic [cak_pkg::SEQ_W-1:0]   corrupt_target_reg;
    logic [cak_pkg::SEQ_W-1:0]   corrupt_target_next;
    logic [cak_pkg::SEQ_W-1:0]   exp_mem [MAX_CLIENTS];
    logic [cak_pkg::SEQ_W-1:0]   exp_rd_reg;
    cak_pkg::job_t               job_reg;
    logic [SLOT_W-1:0]           slot_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    cak_pkg::out_item_t          out_reg;
    cak_pkg::out_item_t          result;
    logic [cak_pkg::SEQ_W-1:0]   exp_cur;
    logic [cak_pkg::SEQ_W-1:0]   exp_wdata;
    logic                        out_free;
    logic                        fire;
    logic                        emit;
    logic                        mem_we;
    logic                        cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign out_free  = !out_valid_reg || out_ready;
    assign fire      = (state_reg == S_EXEC) && out_free;
    assign emit      = fire && job_reg.good;
    assign mem_we    = fire && !job_reg.table_full;
    // a new client starts at one
    assign exp_cur   = job_reg.fresh ? cak_pkg::SEQ_ONE : exp_rd_reg;

    always_comb
    begin
        result              = '0;
        exp_wdata           = exp_cur;
        drop_target_next    = drop_target_reg;
        corrupt_target_next = corrupt_target_reg;
        drop_period_next    = drop_period_reg;
        corrupt_period_next = corrupt_period_reg;
        result.client_slot  = cak_pkg::SLOT_OUT_W'(slot_reg);
        if (job_reg.table_full)
        begin
            result.client_slot = '0;
            result.status      = cak_pkg::ST_FULL;
        end
        else if (!job_reg.good)
        begin
            // bad packet only seeds the new client's expected sequence
        end
        else if (job_reg.seq_num == corrupt_target_reg)
        begin
            result.ack_num      = exp_cur - 1'b1;
            result.status       = cak_pkg::ST_CORRUPT;
            if (fire)
            begin
                corrupt_target_next = corrupt_target_reg + corrupt_period_reg;
            end
        end
        else if (job_reg.seq_num == drop_target_reg)
        begin
            result.ack_num   = exp_cur - 1'b1;
            result.status    = cak_pkg::ST_DROP;
            if (fire)
            begin
                drop_target_next = drop_target_reg + drop_period_reg;
            end
        end
        else if (job_reg.seq_num == exp_cur)
        begin
            result.ack_num = exp_cur;
            result.status  = cak_pkg::ST_ACCEPT;
            if (exp_cur == job_reg.total_packets)
            begin
                result.transfer_done = 1'b1;
            end
            else
            begin
                exp_wdata = exp_cur + 1'b1;
            end
        end
        else
        begin
            result.ack_num = exp_cur - 1'b1;
            result.status  = cak_pkg::ST_ORDER;
        end

        if (cfg_write)
        begin
            unique case (cfg_index)
                cak_pkg::REG_DROP_PERIOD:
                begin
                    drop_period_next = cfg_data;
                    drop_target_next = cfg_data;
                end
                cak_pkg::REG_CORRUPT_PERIOD:
                begin
                    corrupt_period_next = cfg_data;
                    corrupt_target_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            out_valid_reg      <= 1'b0;
            drop_period_reg    <= '0;
            corrupt_period_reg <= '0;
            drop_target_reg    <= '0;
            corrupt_target_reg <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            out_valid_reg      <= out_valid_next;
            drop_period_reg    <= drop_period_next;
            corrupt_period_reg <= corrupt_period_next;
            drop_target_reg    <= drop_target_next;
            corrupt_target_reg <= corrupt_target_next;
        end
    end

    // expected sequence store, registered read
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            exp_rd_reg <= exp_mem[q_slot];
            job_reg    <= q_job;
            slot_reg   <= q_slot;
        end
        if (mem_we)
        begin
            exp_mem[slot_reg] <= exp_wdata;
        end
        if (emit)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result appeared without execution");

    a_pop_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == S_EXEC))
        else $error("pop did not start execution");

    a_exec_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EXEC) && !out_free) |=> (state_reg == S_EXEC))
        else $error("execution left while output blocked");

endmodule

// ===== rtl/core/cumulative_ack_receiver.sv =====
// each good packet, or bad packet from a new client, is popped in the idle state and finished in
// the execute state by the read-modify-write of the expected sequence store; execute holds while
// the output is blocked; other bad packets are dropped at the input and never reach the queue
// reset: client table empty, periods and injection targets zero, queue and output empty
// no clearing pass after reset
module cumulative_ack_receiver #(
    parameter int MAX_CLIENTS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  cak_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output cak_pkg::out_item_t                out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cak_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cak_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SLOT_W  = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int ENTRY_W = SLOT_W + $bits(cak_pkg::job_t);

    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    logic [SLOT_W-1:0]   push_slot;
    cak_pkg::job_t       push_job;
    logic [SLOT_W-1:0]   pop_slot;
    cak_pkg::job_t       pop_job;
    logic [ENTRY_W-1:0]  pop_entry;

    cak_front #(
        .MAX_CLIENTS (MAX_CLIENTS),
        .SLOT_W      (SLOT_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_slot   (push_slot),
        .q_job    (push_job)
    );

    cak_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (cak_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_slot, push_job}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_entry),
        .empty     (q_empty)
    );

    assign pop_slot = pop_entry[ENTRY_W-1:$bits(cak_pkg::job_t)];
    assign pop_job  = cak_pkg::job_t'(pop_entry[$bits(cak_pkg::job_t)-1:0]);

    cak_back #(
        .MAX_CLIENTS (MAX_CLIENTS),
        .SLOT_W      (SLOT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_slot    (pop_slot),
        .q_job     (pop_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== verif/cumulative_ack_receiver_tb.sv =====
`timescale 1ns / 1ps

module cumulative_ack_receiver_tb;

    localparam int CLIENTS      = 16;
    localparam int RANDOM_ITEMS = 205;
    localparam int SETTLE       = 8;
    localparam int CYCLE_LIMIT  = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                clk_unused_guard;
    logic       in_valid = 1'b0;
    logic       in_ready;
    cak_pkg::in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    cak_pkg::out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [cak_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [cak_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor state
    logic [cak_pkg::PORT_W-1:0] port_tab [CLIENTS];
    bit                         used_tab [CLIENTS];
    logic [cak_pkg::SEQ_W-1:0]  exp_tab [CLIENTS];
    logic [cak_pkg::SEQ_W-1:0]  drop_per = '0;
    logic [cak_pkg::SEQ_W-1:0]  corrupt_per = '0;
    logic [cak_pkg::SEQ_W-1:0]  drop_tgt = '0;
    logic [cak_pkg::SEQ_W-1:0]  corrupt_tgt = '0;
    cak_pkg::out_item_t         ack_q [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count = 0;
    int cycle_count = 0;
    int packet_count = 0;
    int ack_count = 0;
    int done_count = 0;
    int status_seen [5];

    cumulative_ack_receiver #(
        .MAX_CLIENTS(CLIENTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d acks outstanding", cycle_count,
                     ack_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (error_count < 40)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic int find_client(input logic [cak_pkg::PORT_W-1:0] port);
        for (int i = 0; i < CLIENTS; i++)
            if (used_tab[i] && port_tab[i] == port)
                return i;
        return -1;
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < CLIENTS; i++)
            if (!used_tab[i])
                return i;
        return -1;
    endfunction

    task automatic apply_reg(input logic [cak_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [cak_pkg::CFG_DATA_W-1:0] val);
        if (idx == cak_pkg::REG_DROP_PERIOD)
        begin
            drop_per = val;
            drop_tgt = val;
        end
        else if (idx == cak_pkg::REG_CORRUPT_PERIOD)
        begin
            corrupt_per = val;
            corrupt_tgt = val;
        end
    endtask

    task automatic predict_ack(input cak_pkg::in_item_t pkt);
        int                        slot;
        cak_pkg::out_item_t        res;
        logic [cak_pkg::SEQ_W-1:0] e;
        slot = find_client(pkt.src_port);
        if (slot < 0)
        begin
            slot = free_slot();
            if (slot >= 0)
            begin
                used_tab[slot] = 1'b1;
                port_tab[slot] = pkt.src_port;
                exp_tab[slot] = cak_pkg::SEQ_ONE;
            end
        end
        if (!pkt.crc_ok)
            return;
        res = '0;
        if (slot < 0)
            res.status = cak_pkg::ST_FULL;
        else
        begin
            e = exp_tab[slot];
            res.client_slot = slot[cak_pkg::SLOT_OUT_W-1:0];
            if (pkt.seq_num == corrupt_tgt)
            begin
                res.ack_num = e - cak_pkg::SEQ_ONE;
                res.status = cak_pkg::ST_CORRUPT;
                corrupt_tgt = corrupt_tgt + corrupt_per;
            end
            else if (pkt.seq_num == drop_tgt)
            begin
                res.ack_num = e - cak_pkg::SEQ_ONE;
                res.status = cak_pkg::ST_DROP;
                drop_tgt = drop_tgt + drop_per;
            end
            else if (pkt.seq_num == e)
            begin
                res.ack_num = e;
                res.status = cak_pkg::ST_ACCEPT;
                if (e == pkt.total_packets)
                    res.transfer_done = 1'b1;
                else
                    exp_tab[slot] = e + cak_pkg::SEQ_ONE;
            end
            else
            begin
                res.ack_num = e - cak_pkg::SEQ_ONE;
                res.status = cak_pkg::ST_ORDER;
            end
        end
        ack_q.push_back(res);
    endtask

    task automatic check_ack(input cak_pkg::out_item_t got);
        cak_pkg::out_item_t want;
        if (ack_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected ack %0d status %0d slot %0d",
                                      got.ack_num, got.status, got.client_slot));
            return;
        end
        want = ack_q.pop_front();
        ack_count++;
        status_seen[int'(want.status)]++;
        if (want.transfer_done)
            done_count++;
        if (got.ack_num !== want.ack_num)
            report_mismatch($sformatf("ack_num %0d, expected %0d", got.ack_num,
                                      want.ack_num));
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status,
                                      want.status));
        if (got.client_slot !== want.client_slot)
            report_mismatch($sformatf("client_slot %0d, expected %0d",
                                      got.client_slot, want.client_slot));
        if (got.transfer_done !== want.transfer_done)
            report_mismatch($sformatf("transfer_done %0b, expected %0b",
                                      got.transfer_done, want.transfer_done));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_ack(out_data);
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_packet(input cak_pkg::in_item_t pkt);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= pkt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_ack(pkt);
        packet_count++;
    endtask

    // valid is left high so back-to-back writes follow without a gap
    task automatic write_reg(input logic [cak_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [cak_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, val);
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        while (ack_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic program_periods(input logic [cak_pkg::SEQ_W-1:0] dp,
                                   input logic [cak_pkg::SEQ_W-1:0] cp);
        quiesce();
        write_reg(cak_pkg::REG_DROP_PERIOD, dp);
        write_reg(cak_pkg::REG_CORRUPT_PERIOD, cp);
        cfg_valid <= 1'b0;
    endtask

    function automatic cak_pkg::in_item_t make_packet(
        input logic [cak_pkg::PORT_W-1:0] port,
        input logic [cak_pkg::SEQ_W-1:0]  seq,
        input logic [cak_pkg::SEQ_W-1:0]  total,
        input logic                       good);
        cak_pkg::in_item_t pkt;
        pkt.src_port = port;
        pkt.seq_num = seq;
        pkt.total_packets = total;
        pkt.crc_ok = good;
        return pkt;
    endfunction

    // mostly go-back-n traffic from known clients, some noise
    function automatic cak_pkg::in_item_t random_packet();
        cak_pkg::in_item_t         pkt;
        int                        slot;
        int                        r;
        logic [cak_pkg::SEQ_W-1:0] e;
        pkt.crc_ok = ($urandom_range(0, 99) < 88);
        if ($urandom_range(0, 99) < 10)
        begin
            pkt.src_port = 16'($urandom);
            pkt.seq_num = 16'($urandom);
            pkt.total_packets = 16'($urandom);
            return pkt;
        end
        slot = $urandom_range(0, CLIENTS - 1);
        e = exp_tab[slot];
        pkt.src_port = port_tab[slot];
        r = $urandom_range(0, 99);
        if (r < 62)
            pkt.seq_num = e;
        else if (r < 70)
            pkt.seq_num = e + 16'($urandom_range(1, 3));
        else if (r < 76)
            pkt.seq_num = e - cak_pkg::SEQ_ONE;
        else if (r < 84)
            pkt.seq_num = corrupt_tgt;
        else if (r < 92)
            pkt.seq_num = drop_tgt;
        else
            pkt.seq_num = 16'($urandom);
        if ($urandom_range(0, 99) < 80)
            pkt.total_packets = e + 16'($urandom_range(0, 3));
        else
            pkt.total_packets = 16'($urandom);
        return pkt;
    endfunction

    task automatic test_in_order_and_done();
        // targets are still zero from reset
        send_packet(make_packet(16'h0000, 16'd0, 16'd3, 1'b1));
        send_packet(make_packet(16'h0000, 16'd0, 16'd3, 1'b1));
        send_packet(make_packet(16'h0000, 16'd1, 16'd3, 1'b1));
        send_packet(make_packet(16'h0000, 16'd2, 16'd3, 1'b1));
        send_packet(make_packet(16'h0000, 16'd3, 16'd3, 1'b1));
        send_packet(make_packet(16'h0000, 16'd3, 16'd3, 1'b1));
        send_packet(make_packet(16'h0000, 16'd9, 16'd3, 1'b1));
        // bad packet still claims a slot
        send_packet(make_packet(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        send_packet(make_packet(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send_packet(make_packet(16'hFFFF, 16'd1, 16'hFFFF, 1'b1));
    endtask

    task automatic test_injection_order();
        quiesce();
        write_reg(cak_pkg::REG_DROP_PERIOD, 16'd6);
        write_reg(cak_pkg::REG_CORRUPT_PERIOD, 16'd6);
        write_reg(8'hFF, 16'hFFFF);
        write_reg(8'h80, 16'h0000);
        cfg_valid <= 1'b0;
        send_packet(make_packet(16'h1234, 16'd6, 16'd4, 1'b1));
        send_packet(make_packet(16'h1234, 16'd6, 16'd4, 1'b1));
        send_packet(make_packet(16'h1234, 16'd12, 16'd4, 1'b1));
        send_packet(make_packet(16'h1234, 16'd1, 16'd4, 1'b1));
        send_packet(make_packet(16'h1234, 16'd12, 16'd4, 1'b1));
        send_packet(make_packet(16'h1234, 16'd3, 16'd4, 1'b1));
    endtask

    task automatic test_table_full();
        logic [cak_pkg::PORT_W-1:0] port;
        while (free_slot() >= 0)
        begin
            port = 16'($urandom);
            if (find_client(port) < 0)
                send_packet(make_packet(port, 16'($urandom), 16'($urandom), 1'b0));
        end
        do
            port = 16'($urandom);
        while (find_client(port) >= 0);
        send_packet(make_packet(port, 16'd1, 16'd1, 1'b1));
        send_packet(make_packet(port, 16'd1, 16'd1, 1'b0));
    endtask

    task automatic test_random_traffic(input int s_idle, input int r_idle,
                                       input logic [cak_pkg::SEQ_W-1:0] dp,
                                       input logic [cak_pkg::SEQ_W-1:0] cp);
        program_periods(dp, cp);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_packet(random_packet());
    endtask

    // fixed targets with zero periods, then targets that wrap past 16 bits
    task automatic test_sequence_wrap();
        program_periods(16'd0, 16'd0);
        send_packet(make_packet(16'h1234, 16'd0, 16'd0, 1'b1));
        send_packet(make_packet(16'h1234, 16'd0, 16'd0, 1'b1));
        send_packet(make_packet(16'h1234, 16'd7, 16'd0, 1'b1));
        program_periods(16'hFFF0, 16'hFFF8);
        send_packet(make_packet(16'h1234, 16'hFFF8, 16'd0, 1'b1));
        send_packet(make_packet(16'h1234, 16'hFFF0, 16'd0, 1'b1));
        send_packet(make_packet(16'h1234, 16'hFFF0, 16'd0, 1'b1));
        send_packet(make_packet(16'h1234, 16'hFFE0, 16'd0, 1'b1));
    endtask

    initial
    begin
        for (int i = 0; i < CLIENTS; i++)
        begin
            used_tab[i] = 1'b0;
            port_tab[i] = '0;
            exp_tab[i] = '0;
        end
        foreach (status_seen[i])
            status_seen[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 8;
        recv_idle_pct = 72;
        test_in_order_and_done();
        test_injection_order();
        test_table_full();
        test_random_traffic(8, 72, 16'($urandom_range(2, 9)), 16'hFFFF);
        test_random_traffic(72, 8, 16'hFFFF, 16'($urandom_range(1, 5)));
        test_random_traffic(0, 0, 16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)));
        test_sequence_wrap();
        quiesce();

        $display("sent %0d packets, checked %0d acks: %0d in order (%0d final), %0d late",
                 packet_count, ack_count, status_seen[0], done_count, status_seen[1]);
        $display("injected %0d drops and %0d corruptions, %0d table full, %0d errors",
                 status_seen[2], status_seen[3], status_seen[4], error_count);
        if (error_count == 0 && ack_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/cak_pkg.sv
rtl/core/cak_front.sv
rtl/core/cak_fifo.sv
rtl/core/cak_back.sv
rtl/core/cumulative_ack_receiver.sv
verif/cumulative_ack_receiver_tb.sv
